@@ rtl/core/pf24ul_pkg.sv @@
// ----------------------------------------------------------------------------
// pf24ul_pkg
// Shared types and constants for the packed float24 uniform loader.
// ----------------------------------------------------------------------------
`default_nettype none

package pf24ul_pkg;

   localparam int WORD_W  = 32;
   localparam int F24_W   = 24;
   localparam int INDEX_W = 8;
   localparam int COUNT_W = 3;
   localparam int SLOTS   = 4;

   // first uniform index that is rejected
   localparam logic [INDEX_W-1:0] UNIFORM_LIMIT = 8'd96;

   // words per vector in each packing mode
   localparam logic [COUNT_W-1:0] WORDS_F24 = 3'd3;
   localparam logic [COUNT_W-1:0] WORDS_F32 = 3'd4;

   // float32 -> float24 exponent handling
   localparam logic [7:0] EXP_REBIAS = 8'd64;
   localparam logic [7:0] EXP_MAX    = 8'd127;

   typedef enum logic {
      CMD_SETUP = 1'b0,
      CMD_DATA  = 1'b1
   } command_type;

   typedef enum logic {
      STATUS_WRITTEN  = 1'b0,
      STATUS_REJECTED = 1'b1
   } status_type;

   typedef struct packed {
      command_type        command;
      logic [WORD_W-1:0]  word;
      logic [INDEX_W-1:0] set_index;
      logic               set_float32;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [INDEX_W-1:0] uniform_slot;
      logic [F24_W-1:0]   comp_x;
      logic [F24_W-1:0]   comp_y;
      logic [F24_W-1:0]   comp_z;
      logic [F24_W-1:0]   comp_w;
   } rsp_type;

   // collected words, entry i is word i of the vector
   typedef logic [SLOTS-1:0][WORD_W-1:0] words_type;

   typedef struct packed {
      logic [F24_W-1:0] x;
      logic [F24_W-1:0] y;
      logic [F24_W-1:0] z;
      logic [F24_W-1:0] w;
   } comps_type;

endpackage

`default_nettype wire

@@ rtl/core/pf24ul_f24_conv.sv @@
// ----------------------------------------------------------------------------
// pf24ul_f24_conv
// Float32 to float24 conversion: truncate, rebias, flush and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module pf24ul_f24_conv (
   input  wire logic [pf24ul_pkg::WORD_W-1:0] word,
   output logic      [pf24ul_pkg::F24_W-1:0]  f24
);

   logic        sign;
   logic [7:0]  exp_raw;
   logic [7:0]  exp_reb;
   logic [15:0] mant;

   assign sign    = word[31];
   assign exp_raw = word[30:23];
   assign mant    = word[22:7];
   assign exp_reb = exp_raw - pf24ul_pkg::EXP_REBIAS;

   always_comb begin
      if (exp_raw <= pf24ul_pkg::EXP_REBIAS) begin
         // underflow, zero and denormal: flush to signed zero
         f24 = {sign, 23'd0};
      end else if (exp_reb > pf24ul_pkg::EXP_MAX) begin
         f24 = {sign, pf24ul_pkg::EXP_MAX[6:0], mant};
      end else begin
         f24 = {sign, exp_reb[6:0], mant};
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/pf24ul_unpack.sv @@
// ----------------------------------------------------------------------------
// pf24ul_unpack
// Turns the collected words into four float24 components for either mode.
// ----------------------------------------------------------------------------
`default_nettype none

module pf24ul_unpack (
   input  wire logic                  float32_mode,
   input  wire pf24ul_pkg::words_type words,
   output pf24ul_pkg::comps_type      comps
);

   logic [pf24ul_pkg::SLOTS-1:0][pf24ul_pkg::F24_W-1:0] conv;

   for (genvar i = 0; i < pf24ul_pkg::SLOTS; i++) begin : g_conv
      pf24ul_f24_conv u_conv (
         .word (words[i]),
         .f24  (conv[i])
      );
   end

   always_comb begin
      if (float32_mode) begin
         // word i lands in component 3-i
         comps.w = conv[0];
         comps.z = conv[1];
         comps.y = conv[2];
         comps.x = conv[3];
      end else begin
         comps.w = words[0][31:8];
         comps.z = {words[0][7:0], words[1][31:16]};
         comps.y = {words[1][15:0], words[2][31:24]};
         comps.x = words[2][23:0];
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/packed_float24_uniform_loader.sv @@
// ----------------------------------------------------------------------------
// packed_float24_uniform_loader
// Float-uniform upload port: collects data words into float24 vectors.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one command item per handshake. A set-up item
//   (command 0) loads the starting uniform index and the packing mode. A data
//   item (command 1) adds one word to the vector being collected: three words
//   complete a vector in packed float24 mode, four in float32 mode. A set-up
//   item does not clear the word count.
//   Each completed vector gives one item on the rsp channel: the four float24
//   components and the uniform slot, after which the index advances. A slot
//   at or above the limit gives a rejected status with zero components and
//   the index stays put.
//   A completing data item passes the input register, then the result
//   register, which raises rsp_valid; a stalled rsp can hold the item in
//   the input register before it moves on.
//   Throughput: one item per cycle while req_stall is low, set by the
//   single pass from the input to the result register.
//   Reset clears the word count, the index, the mode and both valid flags.
//   A stalled rsp holds its item; the input register still drains items
//   that produce no result, and req_stall rises only when a completing
//   item must wait for the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_float24_uniform_loader (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire pf24ul_pkg::req_type req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output pf24ul_pkg::rsp_type      rsp_data
);

   // input register
   logic                s1_valid_ff, s1_valid_in;
   pf24ul_pkg::req_type s1_item_ff, s1_item_in;

   // block state
   pf24ul_pkg::words_type                store_ff;
   logic [pf24ul_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [pf24ul_pkg::INDEX_W-1:0]       index_ff, index_in;
   logic                                 mode_ff, mode_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   pf24ul_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                           is_data;
   logic [pf24ul_pkg::COUNT_W-1:0] count_inc;
   logic [pf24ul_pkg::COUNT_W-1:0] need;
   logic                           complete;
   logic                           reject;
   logic                           out_free;
   logic                           s1_go;
   logic                           req_take;
   pf24ul_pkg::words_type          words;
   pf24ul_pkg::comps_type          comps;

   assign is_data   = (s1_item_ff.command == pf24ul_pkg::CMD_DATA);
   assign count_inc = count_ff + 3'd1;
   assign need      = mode_ff ? pf24ul_pkg::WORDS_F32 : pf24ul_pkg::WORDS_F24;
   assign complete  = is_data && (count_inc >= need);
   assign reject    = (index_ff >= pf24ul_pkg::UNIFORM_LIMIT);

   // result register can load when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // the held item retires now unless it must wait for the result register
   assign s1_go     = s1_valid_ff && (!complete || out_free);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;

   // merge the incoming word into the slot it will occupy
   always_comb begin
      words = store_ff;
      words[count_ff[1:0]] = s1_item_ff.word;
   end

   pf24ul_unpack u_unpack (
      .float32_mode (mode_ff),
      .words        (words),
      .comps        (comps)
   );

   // input register control
   always_comb begin
      s1_item_in  = s1_item_ff;
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_item_in  = req_data;
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   // state update as the held item retires
   always_comb begin
      count_in = count_ff;
      index_in = index_ff;
      mode_in  = mode_ff;
      if (s1_go) begin
         if (!is_data) begin
            index_in = s1_item_ff.set_index;
            mode_in  = s1_item_ff.set_float32;
         end else if (complete) begin
            count_in = '0;
            if (!reject) begin
               index_in = index_ff + 8'd1;
            end
         end else begin
            count_in = count_inc;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_go && complete) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.uniform_slot = index_ff;
         if (reject) begin
            rsp_data_in.status = pf24ul_pkg::STATUS_REJECTED;
            rsp_data_in.comp_x = '0;
            rsp_data_in.comp_y = '0;
            rsp_data_in.comp_z = '0;
            rsp_data_in.comp_w = '0;
         end else begin
            rsp_data_in.status = pf24ul_pkg::STATUS_WRITTEN;
            rsp_data_in.comp_x = comps.x;
            rsp_data_in.comp_y = comps.y;
            rsp_data_in.comp_z = comps.z;
            rsp_data_in.comp_w = comps.w;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         index_ff     <= '0;
         mode_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         index_ff     <= index_in;
         mode_ff      <= mode_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_data_ff <= rsp_data_in;
      if (s1_go && is_data) begin
         store_ff[count_ff[1:0]] <= s1_item_ff.word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a partial vector never holds four or more words
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd3)
      else $error("word count out of range");

   // stall only while an item is held
   a_stall_held : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("stall without a held item");

   // a rejected vector carries zero components
   a_reject_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == pf24ul_pkg::STATUS_REJECTED) |->
      (rsp_data_ff.comp_x == '0 && rsp_data_ff.comp_y == '0 &&
       rsp_data_ff.comp_z == '0 && rsp_data_ff.comp_w == '0))
      else $error("rejected vector with nonzero components");

   // an accepted vector advances the index by one
   a_index_adv : assert property (@(posedge clock) disable iff (reset)
      (s1_go && complete && !reject) |=> (index_ff == $past(index_ff) + 8'd1))
      else $error("index did not advance");

endmodule

`default_nettype wire

@@ tb/sv/packed_float24_uniform_loader_tb.sv @@
// ----------------------------------------------------------------------------
// packed_float24_uniform_loader_tb
// Self-checking bench for the float-uniform upload port: a queue-fed driver
// sends set-up and data items, a scoreboard predicts each completed vector
// (float24 unpacking, float32 conversion, slot limit) and checks every rsp item.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_float24_uniform_loader_tb;

   import pf24ul_pkg::*;

   localparam int RANDOM_ITEMS = 1800;
   localparam int PHASE_LEN    = 610;    // items per idling phase
   localparam int HOLD_AT      = 300;    // accepted items before the long rsp hold-off
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   packed_float24_uniform_loader u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Commands waiting to be sent and vectors waiting to come back.
   req_type pending_cmds[$];
   rsp_type pending_vectors[$];

   // Shadow copy of the loader state.
   logic [WORD_W-1:0]  stored_words [SLOTS] = '{default: '0};
   logic [COUNT_W-1:0] word_tally = '0;
   logic [INDEX_W-1:0] slot_index = '0;
   logic               f32_mode = 1'b0;

   int req_count = 0;        // accepted req items, updated only at clock edges
   int rsp_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int errors = 0;
   int written_vectors = 0;
   int rejected_vectors = 0;
   int f32_vectors = 0;
   int setups_seen = 0;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Float32 to float24: keep sign, truncate mantissa to 16 bits, rebias the
   // exponent by 64, flush underflow to signed zero, clamp overflow to 127.
   function automatic logic [F24_W-1:0] to_float24(logic [WORD_W-1:0] w);
      logic [7:0] ex;
      ex = w[30:23];
      if (ex <= EXP_REBIAS)
         return {w[31], 23'd0};
      ex = ex - EXP_REBIAS;
      if (ex > EXP_MAX)
         ex = EXP_MAX;
      return {w[31], ex[6:0], w[22:7]};
   endfunction

   // Apply one accepted item to the shadow state; queue a vector on completion.
   task automatic predict_vector(input req_type it);
      rsp_type            v;
      logic [COUNT_W-1:0] need;
      if (it.command == CMD_SETUP) begin
         slot_index = it.set_index;
         f32_mode   = it.set_float32;
         setups_seen++;
         return;
      end
      stored_words[word_tally[1:0]] = it.word;
      word_tally = word_tally + 3'd1;
      need = f32_mode ? WORDS_F32 : WORDS_F24;
      if (word_tally < need)
         return;
      word_tally = '0;
      v = '0;
      v.uniform_slot = slot_index;
      if (slot_index >= UNIFORM_LIMIT) begin
         // out of range: zero components, index holds
         v.status = STATUS_REJECTED;
         rejected_vectors++;
      end else begin
         v.status = STATUS_WRITTEN;
         if (f32_mode) begin
            v.comp_w = to_float24(stored_words[0]);
            v.comp_z = to_float24(stored_words[1]);
            v.comp_y = to_float24(stored_words[2]);
            v.comp_x = to_float24(stored_words[3]);
            f32_vectors++;
         end else begin
            v.comp_w = stored_words[0][31:8];
            v.comp_z = {stored_words[0][7:0], stored_words[1][31:16]};
            v.comp_y = {stored_words[1][15:0], stored_words[2][31:24]};
            v.comp_x = stored_words[2][23:0];
         end
         slot_index = slot_index + 8'd1;
         written_vectors++;
      end
      pending_vectors.push_back(v);
   endtask

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic req_type setup_item(logic [INDEX_W-1:0] idx, logic f32);
      req_type it;
      it.command     = CMD_SETUP;
      it.word        = $urandom;       // ignored by set-up
      it.set_index   = idx;
      it.set_float32 = f32;
      return it;
   endfunction

   function automatic req_type data_item(logic [WORD_W-1:0] w);
      req_type it;
      it.command     = CMD_DATA;
      it.word        = w;
      it.set_index   = INDEX_W'($urandom_range(255));   // ignored by data
      it.set_float32 = 1'($urandom_range(1));
      return it;
   endfunction

   // Random word; often force an exponent at a conversion boundary.
   function automatic logic [WORD_W-1:0] random_word();
      logic [WORD_W-1:0] w;
      logic [7:0]        edges [13] = '{8'd0, 8'd1, 8'd63, 8'd64, 8'd65, 8'd66, 8'd127,
                                        8'd128, 8'd190, 8'd191, 8'd192, 8'd254, 8'd255};
      w = $urandom;
      if ($urandom_range(99) < 40)
         w[30:23] = edges[4'($urandom_range(12))];
      if ($urandom_range(99) < 5)
         w[22:0] = $urandom_range(1) ? '1 : '0;
      return w;
   endfunction

   function automatic int phase_of(int n);
      if (n < PHASE_LEN)
         return 0;
      if (n < 2 * PHASE_LEN)
         return 1;
      return 2;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: take the next item when the current one is gone or none is held.
   // ------------------------------------------------------------------------
   req_type next_cmd;
   int      send_idle_pct;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         case (phase_of(req_count))
            0: send_idle_pct = 9;
            1: send_idle_pct = 65;
            default: send_idle_pct = 0;
         endcase
         // keep offering items through the long hold-off so the block backs up
         if (hold_left != 0)
            send_idle_pct = 0;
         if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_cmd = pending_cmds.pop_front();
            req_data  <= next_cmd;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stall per phase, plus one long hold-off.
   // ------------------------------------------------------------------------
   int take_stall_pct;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && req_count >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         case (phase_of(req_count))
            0: take_stall_pct = 65;
            1: take_stall_pct = 9;
            default: take_stall_pct = 0;
         endcase
         rsp_stall <= ($urandom_range(99) < take_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predict on each accepted req item, check each accepted rsp item.
   // ------------------------------------------------------------------------
   rsp_type want;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_vector(req_data);
            req_count <= req_count + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_count <= rsp_count + 1;
            if (pending_vectors.size() == 0) begin
               $display("%0t: unexpected vector, expected none actual %h", $time, rsp_data);
               errors++;
            end else begin
               want = pending_vectors.pop_front();
               report_field("status", 32'(want.status), 32'(rsp_data.status));
               report_field("uniform_slot", 32'(want.uniform_slot),
                            32'(rsp_data.uniform_slot));
               report_field("comp_x", 32'(want.comp_x), 32'(rsp_data.comp_x));
               report_field("comp_y", 32'(want.comp_y), 32'(rsp_data.comp_y));
               report_field("comp_z", 32'(want.comp_z), 32'(rsp_data.comp_z));
               report_field("comp_w", 32'(want.comp_w), 32'(rsp_data.comp_w));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   int added;

   initial begin
      // packed float24: all-ones / all-zeros words, then a mixed pattern
      pending_cmds.push_back(setup_item(8'd0, 1'b0));
      pending_cmds.push_back(data_item(32'hFFFF_FFFF));
      pending_cmds.push_back(data_item(32'h0000_0000));
      pending_cmds.push_back(data_item(32'h1234_5678));
      pending_cmds.push_back(data_item(32'h0000_0000));
      pending_cmds.push_back(data_item(32'hFFFF_FFFF));
      pending_cmds.push_back(data_item(32'hA5C3_0F96));
      // float32 near the limit: zero, negative denormal, exponent 64 flushes,
      // exponent 65 is the smallest kept
      pending_cmds.push_back(setup_item(8'd94, 1'b1));
      pending_cmds.push_back(data_item(32'h0000_0000));
      pending_cmds.push_back(data_item(32'h8000_0001));
      pending_cmds.push_back(data_item(32'h2000_0000));
      pending_cmds.push_back(data_item(32'hA080_0000));
      // slot 95, last one in range: NaN and infinity clamp, largest exact exponent
      pending_cmds.push_back(data_item(32'h7FFF_FFFF));
      pending_cmds.push_back(data_item(32'hFF80_0000));
      pending_cmds.push_back(data_item(32'h5F80_0000));
      pending_cmds.push_back(data_item(32'h3F7F_FF80));
      // switch mode mid-vector to the top index: counter carries, then reject
      pending_cmds.push_back(data_item(32'h89AB_CDEF));
      pending_cmds.push_back(setup_item(8'd255, 1'b0));
      pending_cmds.push_back(data_item(32'h7654_3210));
      pending_cmds.push_back(data_item(32'hFEDC_BA98));
      // index exactly at the limit
      pending_cmds.push_back(setup_item(UNIFORM_LIMIT, 1'b1));
      repeat (4) pending_cmds.push_back(data_item(random_word()));

      // random part: mostly data words, set-ups clustered around the limit
      for (added = 0; added < RANDOM_ITEMS; added++) begin
         if ($urandom_range(99) < 12) begin
            case ($urandom_range(3))
               0: pending_cmds.push_back(setup_item(INDEX_W'($urandom_range(255)),
                                                    1'($urandom_range(1))));
               1: pending_cmds.push_back(setup_item(INDEX_W'($urandom_range(100, 88)),
                                                    1'($urandom_range(1))));
               default: pending_cmds.push_back(setup_item(INDEX_W'($urandom_range(95)),
                                                          1'($urandom_range(1))));
            endcase
         end else begin
            pending_cmds.push_back(data_item(random_word()));
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // drain: all items sent, all vectors back, then let the pipeline settle
      while (pending_cmds.size() != 0 || req_valid)
         @(posedge clock);
      while (pending_vectors.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d items (%0d set-ups), %0d vectors checked", req_count, setups_seen,
               rsp_count);
      $display("run: %0d written (%0d from float32), %0d rejected at the slot limit",
               written_vectors, f32_vectors, rejected_vectors);
      if (errors == 0) begin
         $display("packed_float24_uniform_loader test passed");
      end else begin
         $display("packed_float24_uniform_loader test failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("timeout with %0d vectors outstanding", pending_vectors.size());
      $display("packed_float24_uniform_loader test failed");
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/pf24ul_pkg.sv
rtl/core/pf24ul_f24_conv.sv
rtl/core/pf24ul_unpack.sv
rtl/core/packed_float24_uniform_loader.sv
tb/sv/packed_float24_uniform_loader_tb.sv
